// ===== hw/rtl/ptcr_pkg.sv =====
// ----------------------------------------------------------------------------
// ptcr_pkg: shared definitions for the pulse timing capture/replay block
// Field widths, item kinds, register indexes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package ptcr_pkg;

  // Default store geometry
  localparam int unsigned STORE_DEPTH_DEF  = 4096;
  localparam int unsigned TIMING_WIDTH_DEF = 32;

  // Fixed payload widths
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned GAP_W      = 20;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [GAP_W-1:0] GAP_RESET = 20'd100000;

  // Item kinds; codes 5..7 are unused and leave the state alone
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_READ   = 3'd2,
    KIND_START  = 3'd3,
    KIND_STOP   = 3'd4
  } kind_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP  = 4'd1;

  // Mode register codes
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_REPLAY = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/ptcr_if.sv =====
// ----------------------------------------------------------------------------
// ptcr_if: channel interfaces of the pulse timing capture/replay block
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// Input item channel
interface ptcr_in_if;
  import ptcr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic                      sample_bit;
  logic [IDX_W-1:0]          entry_index;
  logic signed [VALUE_W-1:0] entry_value;

  modport source (output valid, kind, sample_bit, entry_index, entry_value,
                  input ready);
  modport sink   (input valid, kind, sample_bit, entry_index, entry_value,
                  output ready);
endinterface

// Result item channel
interface ptcr_res_if #(
  parameter int unsigned COUNT_WIDTH = $clog2(ptcr_pkg::STORE_DEPTH_DEF + 1)
);
  import ptcr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      drive_level;
  logic signed [VALUE_W-1:0] read_data;
  logic [COUNT_WIDTH-1:0]    entry_count;
  logic                      running;
  logic                      store_full;

  modport source (output valid, drive_level, read_data, entry_count, running,
                  store_full, input ready);
  modport sink   (input valid, drive_level, read_data, entry_count, running,
                  store_full, output ready);
endinterface

// Configuration write channel
interface ptcr_cfg_if;
  import ptcr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pulse_timing_capture_replay_top.sv =====
// ----------------------------------------------------------------------------
// pulse_timing_capture_replay_top: OOK raw pulse width recorder / replayer
// Records signed run lengths of the sampled data bit into a timing store and
// replays them as an output level, with a repeat gap between passes.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  cfg_i   | in  | valid / ready | index, data (mode, repeat_gap)
//  in_i    | in  | valid / ready | kind, sample_bit, entry_index, entry_value
//  res_o   | out | valid / ready | drive_level, read_data, entry_count,
//          |     |               | running, store_full
//
//  Every item passes through the work stage and one result is queued in a
//  two-entry output buffer, so items flow back to back while the buffer has
//  room and no phase is skipped. A replay tick that lands on zero-length
//  phases (zero entries or a zero gap) holds the work stage while each is
//  skipped, as the store's replay read port fetches one entry per cycle.
//  Reset clears all control state at once; the store itself is not cleared,
//  the entry count gates every read. cfg_i is always ready. in_i stalls only
//  while the work stage is busy or the output buffer is full.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_timing_capture_replay_top #(
  parameter int unsigned STORE_DEPTH  = ptcr_pkg::STORE_DEPTH_DEF,
  parameter int unsigned TIMING_WIDTH = ptcr_pkg::TIMING_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptcr_cfg_if.sink   cfg_i,
  ptcr_in_if.sink    in_i,
  ptcr_res_if.source res_o
);
  import ptcr_pkg::*;

  localparam int unsigned AW  = $clog2(STORE_DEPTH);
  localparam int unsigned CW  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned GW  = $clog2(STORE_DEPTH + 3);
  localparam int unsigned TW  = TIMING_WIDTH;
  localparam int unsigned TCW = (TIMING_WIDTH > GAP_W) ? TIMING_WIDTH : GAP_W;

  localparam logic [CW-1:0]  DEPTH_C = CW'(STORE_DEPTH);
  localparam logic [TCW-1:0] TMAX    = TCW'((64'd1 << (TIMING_WIDTH - 1)) - 64'd1);
  localparam logic signed [63:0] VAL_HI = (64'sd1 <<< (TIMING_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] VAL_LO = -VAL_HI - 64'sd1;

  typedef struct packed {
    logic                      drive_level;
    logic signed [VALUE_W-1:0] read_data;
    logic [CW-1:0]             entry_count;
    logic                      running;
    logic                      store_full;
  } res_t;

  // Configuration registers
  logic             mode_q;
  logic [GAP_W-1:0] gap_q;
  logic             cfg_acc;

  // Work-stage input register
  logic                      x_vld_q, x_vld_d;
  logic [KIND_W-1:0]         x_kind_q;
  logic                      x_bit_q;
  logic [IDX_W-1:0]          x_idx_q;
  logic signed [VALUE_W-1:0] x_value_q;
  logic                      in_acc, x_done;

  // Block state
  logic [CW-1:0]  count_q, count_d;
  logic           run_q, run_d;
  logic           last_q, last_d;
  logic [TCW-1:0] tick_q, tick_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic           in_gap_q, in_gap_d;
  logic           out_lvl_q, out_lvl_d;
  logic           full_q, full_d;
  logic [GW-1:0]  guard_q, guard_d;

  // Timing store and its ports
  logic [TW-1:0] store_q [STORE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [TW-1:0] mem_wdata;
  logic [AW-1:0] ra_addr, rb_addr;
  logic [TW-1:0] rd_a_q, rd_b_q;

  // Output buffer
  res_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop, room;
  res_t       res_d;

  // Helpers
  logic [TCW-1:0]     tick_inc;
  logic [TW-1:0]      rec_val;
  logic signed [63:0] app_ext;
  logic [TW-1:0]      app_clamp;
  logic [CW-1:0]      np, np_d;
  logic               ld_gap, rb_neg;
  logic [TW-1:0]      rb_mag;
  logic [TCW-1:0]     tick_ld, tick_st;
  logic               out_ld;
  logic [GW-1:0]      guard_lim, guard_inc;
  logic               need_load, stop_ok;
  logic               rd_hit;

  // ---------------------------------------------------------------------------
  // Handshakes
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = !x_vld_q || x_done;
  assign in_acc      = in_i.valid && in_i.ready;
  assign pop         = res_o.valid && res_o.ready;
  assign room        = (cnt_q != 2'd2) || pop;
  assign push        = x_done;

  // ---------------------------------------------------------------------------
  // Configuration registers; mode is locked while running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RECORD;
      gap_q  <= GAP_RESET;
    end else if (cfg_acc) begin
      case (cfg_i.index)
        REG_MODE: if (!run_q) mode_q <= cfg_i.data[0];
        REG_GAP:  gap_q <= cfg_i.data[GAP_W-1:0];
        default:  ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Record arithmetic: saturating run counter and signed entry
  assign tick_inc = (tick_q < TMAX) ? tick_q + TCW'(1) : tick_q;
  assign rec_val  = last_q ? tick_inc[TW-1:0] : TW'(0) - tick_inc[TW-1:0];

  // Appended value clamped to the signed timing range
  assign app_ext   = 64'(x_value_q);
  assign app_clamp = (app_ext > VAL_HI) ? TW'(VAL_HI) :
                     (app_ext < VAL_LO) ? TW'(VAL_LO) : x_value_q[TW-1:0];

  // ---------------------------------------------------------------------------
  // Replay phase load; rd_b_q always holds the entry at the next position
  assign np        = in_gap_q ? '0 : pos_q + CW'(1);
  assign ld_gap    = (np >= count_q);
  assign rb_neg    = rd_b_q[TW-1];
  assign rb_mag    = rb_neg ? TW'(0) - rd_b_q : rd_b_q;
  assign tick_ld   = ld_gap ? TCW'(gap_q) : TCW'(rb_mag);
  assign out_ld    = ld_gap ? out_lvl_q : ((rd_b_q != '0) && !rb_neg);
  assign guard_lim = GW'(count_q) + GW'(1);
  assign guard_inc = guard_q + GW'(1);
  assign need_load = (tick_q == '0) && (guard_q <= guard_lim);
  assign stop_ok   = !need_load || (tick_ld != '0) || (guard_inc > guard_lim);
  assign tick_st   = need_load ? tick_ld : tick_q;

  // ---------------------------------------------------------------------------
  // Next state of the work stage
  always_comb begin
    count_d   = count_q;
    run_d     = run_q;
    last_d    = last_q;
    tick_d    = tick_q;
    pos_d     = pos_q;
    in_gap_d  = in_gap_q;
    out_lvl_d = out_lvl_q;
    full_d    = full_q;
    guard_d   = guard_q;
    mem_we    = 1'b0;
    mem_waddr = count_q[AW-1:0];
    mem_wdata = rec_val;
    x_done    = 1'b0;

    if (x_vld_q) begin
      case (kind_e'(x_kind_q))
        KIND_TICK: begin
          if (!run_q) begin
            x_done = room;
          end else if (mode_q == MODE_RECORD) begin
            x_done = room;
            if (room) begin
              tick_d = tick_inc;
              if (x_bit_q != last_q) begin
                if (count_q < DEPTH_C) begin
                  mem_we  = 1'b1;
                  count_d = count_q + CW'(1);
                end
                last_d = x_bit_q;
                tick_d = '0;
                if (count_d >= DEPTH_C) begin
                  run_d  = 1'b0;
                  full_d = 1'b1;
                end
              end
            end
          end else begin
            // one phase load per cycle until a phase with length is found
            if (need_load) begin
              in_gap_d  = ld_gap;
              pos_d     = np;
              out_lvl_d = out_ld;
              tick_d    = tick_ld;
              guard_d   = guard_inc;
            end
            if (stop_ok && room) begin
              x_done  = 1'b1;
              tick_d  = tick_st - TCW'(tick_st != '0);
              guard_d = '0;
            end
          end
        end
        KIND_APPEND: begin
          x_done = room;
          if (room && !run_q && (count_q < DEPTH_C)) begin
            mem_we    = 1'b1;
            mem_wdata = app_clamp;
            count_d   = count_q + CW'(1);
          end
        end
        KIND_START: begin
          x_done = room;
          if (room) begin
            tick_d    = '0;
            pos_d     = '0;
            in_gap_d  = 1'b1;
            out_lvl_d = 1'b0;
            if (mode_q == MODE_RECORD) begin
              count_d = '0;
              full_d  = 1'b0;
              last_d  = 1'b1;
              run_d   = 1'b1;
            end else begin
              run_d = (count_q != '0);
              if (count_q != '0) tick_d = TCW'(gap_q);
            end
          end
        end
        KIND_STOP: begin
          x_done = room;
          if (room) begin
            run_d     = 1'b0;
            out_lvl_d = 1'b0;
            in_gap_d  = 1'b1;
            tick_d    = '0;
          end
        end
        default: x_done = room;
      endcase
    end
  end

  // Result of the item leaving the work stage
  assign rd_hit = (kind_e'(x_kind_q) == KIND_READ) && (32'(x_idx_q) < 32'(count_q));

  always_comb begin
    res_d.drive_level = (run_d && (mode_q == MODE_REPLAY)) ? out_lvl_d : 1'b0;
    res_d.read_data   = rd_hit ? VALUE_W'(signed'(rd_a_q)) : '0;
    res_d.entry_count = count_d;
    res_d.running     = run_d;
    res_d.store_full  = full_d;
  end

  // ---------------------------------------------------------------------------
  // Control registers
  assign x_vld_d = in_acc ? 1'b1 : (x_done ? 1'b0 : x_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q   <= 1'b0;
      count_q   <= '0;
      run_q     <= 1'b0;
      last_q    <= 1'b1;
      tick_q    <= '0;
      pos_q     <= '0;
      in_gap_q  <= 1'b1;
      out_lvl_q <= 1'b0;
      full_q    <= 1'b0;
      guard_q   <= '0;
    end else begin
      x_vld_q   <= x_vld_d;
      count_q   <= count_d;
      run_q     <= run_d;
      last_q    <= last_d;
      tick_q    <= tick_d;
      pos_q     <= pos_d;
      in_gap_q  <= in_gap_d;
      out_lvl_q <= out_lvl_d;
      full_q    <= full_d;
      guard_q   <= guard_d;
    end
  end

  // Input item payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_kind_q  <= in_i.kind;
      x_bit_q   <= in_i.sample_bit;
      x_idx_q   <= in_i.entry_index;
      x_value_q <= in_i.entry_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Timing store: one write port, two registered read ports with write bypass
  assign ra_addr = AW'(in_i.entry_index);
  assign np_d    = in_gap_d ? '0 : pos_d + CW'(1);
  assign rb_addr = np_d[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[mem_waddr] <= mem_wdata;
  end

  // readback port, loaded as the read item enters the work stage
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_a_q <= (mem_we && (mem_waddr == ra_addr)) ? mem_wdata : store_q[ra_addr];
    end
  end

  // replay port, follows the next load position every cycle
  always_ff @(posedge clk_i) begin
    rd_b_q <= (mem_we && (mem_waddr == rb_addr)) ? mem_wdata : store_q[rb_addr];
  end

  // ---------------------------------------------------------------------------
  // Two-entry output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= res_d;
  end

  assign res_o.valid       = (cnt_q != 2'd0);
  assign res_o.drive_level = buf_q[rd_ptr_q].drive_level;
  assign res_o.read_data   = buf_q[rd_ptr_q].read_data;
  assign res_o.entry_count = buf_q[rd_ptr_q].entry_count;
  assign res_o.running     = buf_q[rd_ptr_q].running;
  assign res_o.store_full  = buf_q[rd_ptr_q].store_full;

endmodule

`default_nettype wire

// ===== test/ptcr_result_compare.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcr_result_compare: status predictor and in-order result comparator
// Follows every accepted configuration write and input item, works out the
// status item the recorder/replayer has to return and compares the returned
// items field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module ptcr_result_compare
  import ptcr_pkg::*;
#(
  parameter int unsigned DEPTH = STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptcr_cfg_if         cfg_mon,
  ptcr_in_if          item_mon,
  ptcr_res_if         res_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned checked_cnt_o,
  output int unsigned pending_cnt_o,
  output int unsigned stored_cnt_o
);

  localparam logic [VALUE_W-1:0] RUN_MAX   = 32'h7FFF_FFFF;
  localparam int unsigned        PRINT_CAP = 40;

  typedef struct packed {
    logic               drive;
    logic [VALUE_W-1:0] rdata;
    logic [12:0]        cnt;
    logic               run;
    logic               full;
  } status_t;

  // Predicted status items still owed by the block
  status_t status_due[$];

  // Shadow of the block state
  logic [VALUE_W-1:0] timing_mem [DEPTH];
  int unsigned        n_entries;
  bit                 rec_run;
  bit                 prev_lvl;
  logic [VALUE_W-1:0] tick_cnt;
  int unsigned        play_idx;
  bit                 gap_phase;
  bit                 out_lvl;
  bit                 full_flag;
  bit                 mode_q;
  logic [GAP_W-1:0]   gap_q;

  function automatic logic [VALUE_W-1:0] magnitude(input logic [VALUE_W-1:0] v);
    return v[VALUE_W-1] ? (32'd0 - v) : v;
  endfunction

  // Step to the next replay phase: first entry after a gap, gap after the last
  function automatic void advance_phase();
    if (gap_phase) begin
      gap_phase = 1'b0;
      play_idx  = 0;
    end else begin
      play_idx++;
    end
    if (play_idx >= n_entries || play_idx >= DEPTH) begin
      gap_phase = 1'b1;
      tick_cnt  = 32'(gap_q);
      return;
    end
    out_lvl  = (timing_mem[play_idx] != '0) && !timing_mem[play_idx][VALUE_W-1];
    tick_cnt = magnitude(timing_mem[play_idx]);
  endfunction

  // Zero-length phases are skipped, bounded by n_entries + 2 phase steps
  function automatic void replay_tick();
    int unsigned guard;
    guard = 0;
    while (tick_cnt == '0 && guard <= n_entries + 1) begin
      advance_phase();
      guard++;
    end
    if (tick_cnt != '0) tick_cnt--;
  endfunction

  // Edge tick stores the run including itself; low runs are negated
  function automatic void record_tick(input bit smp);
    if (tick_cnt < RUN_MAX) tick_cnt++;
    if (smp == prev_lvl) return;
    if (n_entries < DEPTH) begin
      timing_mem[n_entries] = prev_lvl ? tick_cnt : (32'd0 - tick_cnt);
      n_entries++;
    end
    prev_lvl = smp;
    tick_cnt = '0;
    if (n_entries >= DEPTH) begin
      rec_run   = 1'b0;
      full_flag = 1'b1;
    end
  endfunction

  function automatic status_t predict_status(input logic [KIND_W-1:0] kind,
                                             input bit smp,
                                             input logic [IDX_W-1:0] ix,
                                             input logic [VALUE_W-1:0] v);
    status_t            s;
    logic [VALUE_W-1:0] rd;
    rd = '0;
    case (kind)
      KIND_TICK: begin
        if (rec_run) begin
          if (mode_q == MODE_RECORD) record_tick(smp);
          else replay_tick();
        end
      end
      KIND_APPEND: begin
        if (!rec_run && n_entries < DEPTH) begin
          timing_mem[n_entries] = v;
          n_entries++;
        end
      end
      KIND_READ: begin
        if (ix < n_entries && ix < DEPTH) rd = timing_mem[ix];
      end
      KIND_START: begin
        tick_cnt  = '0;
        play_idx  = 0;
        gap_phase = 1'b1;
        out_lvl   = 1'b0;
        if (mode_q == MODE_RECORD) begin
          n_entries = 0;
          full_flag = 1'b0;
          prev_lvl  = 1'b1;
          rec_run   = 1'b1;
        end else begin
          rec_run = (n_entries > 0);
          if (rec_run) tick_cnt = 32'(gap_q);
        end
      end
      KIND_STOP: begin
        rec_run   = 1'b0;
        out_lvl   = 1'b0;
        gap_phase = 1'b1;
        tick_cnt  = '0;
      end
      default: ;
    endcase
    s.drive = (rec_run && mode_q == MODE_REPLAY) ? out_lvl : 1'b0;
    s.rdata = rd;
    s.cnt   = 13'(n_entries);
    s.run   = rec_run;
    s.full  = full_flag;
    return s;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= PRINT_CAP)
      $display("%0t: result item %0d: %s is %0h, predicted %0h",
               $time, checked_cnt_o, field, got, want);
  endtask

  // Compare returned items first, then fold in this edge's writes and items
  always @(posedge clk_i or negedge rst_ni) begin : track
    status_t want;
    if (!rst_ni) begin
      status_due.delete();
      n_entries      = 0;
      rec_run        = 1'b0;
      prev_lvl       = 1'b1;
      tick_cnt       = '0;
      play_idx       = 0;
      gap_phase      = 1'b1;
      out_lvl        = 1'b0;
      full_flag      = 1'b0;
      mode_q         = MODE_RECORD;
      gap_q          = GAP_RESET;
      mismatch_cnt_o = 0;
      checked_cnt_o  = 0;
      pending_cnt_o  = 0;
      stored_cnt_o   = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (status_due.size() == 0) begin
          report_mismatch("unexpected item, entry_count", 32'(res_mon.entry_count), '0);
        end else begin
          want = status_due.pop_front();
          if (res_mon.drive_level !== want.drive)
            report_mismatch("drive_level", 32'(res_mon.drive_level), 32'(want.drive));
          if (res_mon.read_data !== want.rdata)
            report_mismatch("read_data", res_mon.read_data, want.rdata);
          if (res_mon.entry_count !== want.cnt)
            report_mismatch("entry_count", 32'(res_mon.entry_count), 32'(want.cnt));
          if (res_mon.running !== want.run)
            report_mismatch("running", 32'(res_mon.running), 32'(want.run));
          if (res_mon.store_full !== want.full)
            report_mismatch("store_full", 32'(res_mon.store_full), 32'(want.full));
          checked_cnt_o++;
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_MODE) begin
          if (!rec_run) mode_q = cfg_mon.data[0];
        end else if (cfg_mon.index == REG_GAP) begin
          gap_q = cfg_mon.data[GAP_W-1:0];
        end
      end
      if (item_mon.valid && item_mon.ready)
        status_due.push_back(predict_status(item_mon.kind, item_mon.sample_bit,
                                            item_mon.entry_index, item_mon.entry_value));
      pending_cnt_o = status_due.size();
      stored_cnt_o  = n_entries;
    end
  end

endmodule

// ===== test/tb_pulse_timing_capture_replay_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_timing_capture_replay_top: recorder/replayer block testbench
// Drives directed and random item sequences through record, append/readback
// and replay sessions under three sender/receiver stall mixes, and reports
// the verdict from the result comparator.
// ----------------------------------------------------------------------------
module tb_pulse_timing_capture_replay_top;
  import ptcr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 4'hF;
  localparam logic [KIND_W-1:0]    KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0]    KIND_SPARE_HI = 3'd7;
  localparam logic [GAP_W-1:0]     GAP_MAX       = '1;
  localparam logic [VALUE_W-1:0]   VALUE_MAX     = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0]   VALUE_MIN     = 32'h8000_0000;
  localparam int unsigned          PHASE_ITEMS   = 350;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned items_sent;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned pending;
  int unsigned stored;

  ptcr_cfg_if cfg_bus ();
  ptcr_in_if  item_bus ();
  ptcr_res_if res_bus ();

  pulse_timing_capture_replay_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (item_bus),
    .res_o  (res_bus)
  );

  ptcr_result_compare u_compare (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_mon        (cfg_bus),
    .item_mon       (item_bus),
    .res_mon        (res_bus),
    .mismatch_cnt_o (mismatches),
    .checked_cnt_o  (checked),
    .pending_cnt_o  (pending),
    .stored_cnt_o   (stored)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side back-pressure
  always @(negedge clk_i) begin
    res_bus.ready <= ($urandom_range(99) >= recv_idle);
  end

  // One item: random idle cycles, then hold until accepted
  task automatic send_item(input logic [KIND_W-1:0] k, input bit s,
                           input logic [IDX_W-1:0] ix, input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle) begin
      item_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid       <= 1'b1;
    item_bus.kind        <= k;
    item_bus.sample_bit  <= s;
    item_bus.entry_index <= ix;
    item_bus.entry_value <= v;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic tick(input bit s);
    send_item(KIND_TICK, s, 12'($urandom), 32'($urandom));
  endtask

  task automatic append(input logic [VALUE_W-1:0] v);
    send_item(KIND_APPEND, 1'($urandom), 12'($urandom), v);
  endtask

  task automatic read_at(input logic [IDX_W-1:0] ix);
    send_item(KIND_READ, 1'($urandom), ix, 32'($urandom));
  endtask

  task automatic start_run();
    send_item(KIND_START, 1'($urandom), 12'($urandom), 32'($urandom));
  endtask

  task automatic stop_run();
    send_item(KIND_STOP, 1'($urandom), 12'($urandom), 32'($urandom));
  endtask

  task automatic any_item();
    send_item(3'($urandom_range(7)), 1'($urandom), 12'($urandom), 32'($urandom));
  endtask

  // Wait until every predicted item has come back
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] ix, input logic [CFG_DATA_W-1:0] d);
    settle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= ix;
    cfg_bus.data  <= d;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Upper data bits are junk the block must drop
  task automatic set_mode(input logic m);
    cfg_write(REG_MODE, ($urandom() & ~32'd1) | 32'(m));
  endtask

  task automatic set_gap(input logic [GAP_W-1:0] g);
    cfg_write(REG_GAP, ($urandom() & 32'hFFF0_0000) | 32'(g));
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    if (stored > 0 && $urandom_range(3) != 0) return 12'($urandom_range(stored - 1));
    return 12'($urandom);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return VALUE_MAX;
      2:       return VALUE_MIN;
      3:       return 32'($urandom);
      default: return 32'($urandom_range(24)) - 32'd12;
    endcase
  endfunction

  function automatic logic [GAP_W-1:0] pick_gap();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 20'd1;
      2:       return GAP_MAX;
      3:       return GAP_RESET;
      default: return 20'($urandom_range(12));
    endcase
  endfunction

  // Recording with level runs of 1..6 ticks and stray items mixed in
  task automatic record_session(input int unsigned n_ticks);
    int unsigned run_left;
    bit          lvl;
    lvl      = 1'($urandom);
    run_left = $urandom_range(1, 6);
    start_run();
    for (int unsigned i = 0; i < n_ticks; i++) begin
      case ($urandom_range(29))
        0: read_at(pick_index());
        1: append(pick_value());
        2: any_item();
        3: start_run();
        default: begin
          tick(lvl);
          run_left--;
          if (run_left == 0) begin
            lvl      = ~lvl;
            run_left = $urandom_range(1, 6);
          end
        end
      endcase
    end
    if ($urandom_range(4) != 0) stop_run();
  endtask

  // Empty the store, then append short timings (or only zeros)
  task automatic reload_store(input int unsigned n, input bit zeros);
    stop_run();
    set_mode(MODE_RECORD);
    start_run();
    stop_run();
    for (int unsigned i = 0; i < n; i++)
      append(zeros ? '0 : 32'($urandom_range(8)) - 32'd4);
  endtask

  task automatic replay_session(input int unsigned n_ticks);
    start_run();
    for (int unsigned i = 0; i < n_ticks; i++) begin
      case ($urandom_range(29))
        0: read_at(pick_index());
        1: append(pick_value());
        2: any_item();
        3: start_run();
        default: tick(1'($urandom));
      endcase
    end
    if ($urandom_range(4) != 0) stop_run();
  endtask

  task automatic load_session(input int unsigned n);
    set_mode(MODE_RECORD);
    if ($urandom_range(3) == 0) begin
      start_run();
      stop_run();
    end
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) append(pick_value());
      else read_at(pick_index());
    end
  endtask

  // Random session mix; a run is sometimes left going across a mode write
  task automatic random_sessions(input int unsigned target);
    while (items_sent < target) begin
      if ($urandom_range(4) != 0) stop_run();
      case ($urandom_range(5))
        0, 1: begin
          set_mode(MODE_RECORD);
          if ($urandom_range(1) != 0) set_gap(pick_gap());
          record_session($urandom_range(10, 60));
        end
        2: load_session($urandom_range(5, 30));
        3, 4: begin
          if ($urandom_range(2) != 0)
            reload_store($urandom_range(1, 12), $urandom_range(4) == 0);
          set_mode(MODE_REPLAY);
          set_gap(pick_gap());
          replay_session($urandom_range(20, 100));
        end
        default: repeat (10) any_item();
      endcase
    end
  endtask

  task automatic directed_items();
    read_at('0);
    send_item(KIND_SPARE_LO, 1'b1, '1, '1);
    send_item(KIND_SPARE_HI, 1'b0, '0, '0);
    tick(1'b1);
    stop_run();
    append(32'd3);
    append(32'hFFFF_FFFE);
    append('0);
    append(VALUE_MAX);
    append(VALUE_MIN);
    for (int unsigned i = 0; i < 5; i++) read_at(12'(i));
    read_at('1);
    cfg_write(REG_SPARE, $urandom());
    set_mode(MODE_REPLAY);
    set_gap('0);
    start_run();
    repeat (5) tick(1'($urandom));
    start_run();
    tick(1'b0);
    stop_run();
    // empty store: replay start ends at once
    set_mode(MODE_RECORD);
    start_run();
    stop_run();
    set_mode(MODE_REPLAY);
    start_run();
    tick(1'b1);
  endtask

  initial begin
    rst_ni               = 1'b0;
    item_bus.valid       = 1'b0;
    item_bus.kind        = KIND_TICK;
    item_bus.sample_bit  = 1'b0;
    item_bus.entry_index = '0;
    item_bus.entry_value = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = REG_MODE;
    cfg_bus.data         = '0;
    send_idle            = 22;
    recv_idle            = 53;
    items_sent           = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_items();
    random_sessions(items_sent + PHASE_ITEMS);
    send_idle = 53;
    recv_idle = 22;
    random_sessions(items_sent + PHASE_ITEMS);
    send_idle = 0;
    recv_idle = 0;
    random_sessions(items_sent + PHASE_ITEMS);

    settle();
    repeat (8) @(negedge clk_i);
    $display("Sent %0d items over recording, append/readback and replay sessions,",
             items_sent);
    $display("under three stall mixes; %0d result items compared, %0d mismatches.",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_pulse_timing_capture_replay_top: PASS");
    end else begin
      $display("tb_pulse_timing_capture_replay_top: FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("tb_pulse_timing_capture_replay_top: FAIL");
    $finish;
  end

endmodule
